>>> design/epdc_pkg.sv
// shared constants and small helpers for the dihedral cosine pipeline
// used by epdc_normal and edge_plane_dihedral_cosine
package epdc_pkg;

  localparam int RegCount = 3;
  localparam int RegIdxWidth = 2;
  localparam int CoordWidth = 20;
  localparam int CoordFracBits = 8;
  localparam int PointWidth = 3 * CoordWidth;
  localparam int NormBits = 24;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_EDGE_START = 2'd0,
    REG_EDGE_END   = 2'd1,
    REG_REFERENCE  = 2'd2
  } reg_idx_t;

endpackage

>>> design/epdc_normal.sv
// rescales one cross product normal to NormBits magnitude, one pipeline stage
// depends on epdc_pkg
module epdc_normal #(
  parameter int NW = 44
) (
  input  logic clk,
  input  logic en,
  input  logic signed [NW-1:0] n0,
  input  logic signed [NW-1:0] n1,
  input  logic signed [NW-1:0] n2,
  output logic [epdc_pkg::NormBits-1:0] mag0,
  output logic [epdc_pkg::NormBits-1:0] mag1,
  output logic [epdc_pkg::NormBits-1:0] mag2,
  output logic [2:0] neg,
  output logic zero
);
  localparam int NB = epdc_pkg::NormBits;
  localparam int EW = NW + NB;

  logic [NW-1:0] a0, a1, a2, mx;
  logic [EW-1:0] w0, w1, w2;
  logic [$clog2(EW+1)-1:0] msb;

  always_comb begin
    a0 = n0[NW-1] ? NW'(-n0) : NW'(n0);
    a1 = n1[NW-1] ? NW'(-n1) : NW'(n1);
    a2 = n2[NW-1] ? NW'(-n2) : NW'(n2);
    mx = a0 | a1 | a2;
    msb = '0;
    for (int i = 0; i < NW; i++) begin
      if (mx[i]) begin
        msb = ($clog2(EW+1))'(i);
      end
    end
    // place the top set bit at position EW-1, then take the top NB bits
    w0 = {{NB{1'b0}}, a0} << ($clog2(EW+1))'(EW - 1 - int'(msb));
    w1 = {{NB{1'b0}}, a1} << ($clog2(EW+1))'(EW - 1 - int'(msb));
    w2 = {{NB{1'b0}}, a2} << ($clog2(EW+1))'(EW - 1 - int'(msb));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= w0[EW-1 -: NB];
      mag1 <= w1[EW-1 -: NB];
      mag2 <= w2[EW-1 -: NB];
      neg  <= {n2[NW-1], n1[NW-1], n0[NW-1]};
      zero <= (mx == '0);
    end
  end
endmodule

>>> design/edge_plane_dihedral_cosine.sv
// top level of the dihedral cosine pipeline
// depends on epdc_pkg and epdc_normal
//
// usage: write edge start, edge end and reference point over the cfg channel
// (cfg_index 0..2, other indexes ignored) while the pipeline is empty.
// each query point is an item on the in channel; the out channel returns
// cosine (signed, COS_FRAC_BITS fraction bits) and a degenerate flag.
// throughput is one item per cycle while the out channel is not stalled; an
// item passes through these registers on its way to the out channel:
// differences, cross products, cross sums, rescale and dot products,
// 25 square root stages, the denominator multiply, COS_FRAC_BITS + 2
// quotient stages and the output register.
// the whole pipeline advances only when its last stage is empty or taken,
// so a stalled receiver holds every item in place and nothing is lost.
// reset clears the points and all valid bits.
module edge_plane_dihedral_cosine #(
  parameter int COS_FRAC_BITS = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [epdc_pkg::RegIdxWidth-1:0] cfg_index,
  input  logic [epdc_pkg::PointWidth-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [epdc_pkg::CoordWidth-1:0] query_x,
  input  logic signed [epdc_pkg::CoordWidth-1:0] query_y,
  input  logic signed [epdc_pkg::CoordWidth-1:0] query_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [COS_FRAC_BITS+1:0] cosine,
  output logic degenerate
);
  localparam int CW = epdc_pkg::CoordWidth;
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW + 2;
  localparam int NB = epdc_pkg::NormBits;
  localparam int SQW = 2 * NB + 2;
  localparam int RW = NB + 1;
  localparam int RSTEPS = RW;
  localparam int SW = 2 * RW;
  localparam int QW = COS_FRAC_BITS + 2;
  localparam int DDW = 2 * NB + 2;
  localparam int ST = 5 + RSTEPS + 1 + QW + 1;
  localparam logic [QW-1:0] One = QW'(1) << COS_FRAC_BITS;
  // near-one thresholds: largest q that is not snapped
  localparam longint PosLim = (longint'(999999999) << COS_FRAC_BITS) / 1000000000;
  localparam longint NegLim = (longint'(99999999) << COS_FRAC_BITS) / 100000000;

  logic [epdc_pkg::PointWidth-1:0] pa, pb, pr;
  logic adv;
  logic [ST-1:0] vld;

  assign cfg_ready = 1'b1;
  assign adv = !vld[ST-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa <= '0;
      pb <= '0;
      pr <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        epdc_pkg::REG_EDGE_START: pa <= cfg_data;
        epdc_pkg::REG_EDGE_END:   pb <= cfg_data;
        epdc_pkg::REG_REFERENCE:  pr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST-2:0], in_valid};
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] ab [3], ar [3], ap [3];
  logic signed [CW-1:0] ca [3], cb [3], cr [3], cp [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = pa[k*CW +: CW];
      cb[k] = pb[k*CW +: CW];
      cr[k] = pr[k*CW +: CW];
    end
    cp[0] = query_x;
    cp[1] = query_y;
    cp[2] = query_z;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ab[k] <= DW'(cb[k]) - DW'(ca[k]);
        ar[k] <= DW'(cr[k]) - DW'(ca[k]);
        ap[k] <= DW'(cp[k]) - DW'(ca[k]);
      end
    end
  end

  // stage 2: products, stage 3: cross sums
  logic signed [2*DW-1:0] pm1 [6], pm2 [6];
  logic signed [NW-1:0] n1 [3], n2 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      pm1[0] <= ab[1] * ar[2]; pm1[1] <= ab[2] * ar[1];
      pm1[2] <= ab[2] * ar[0]; pm1[3] <= ab[0] * ar[2];
      pm1[4] <= ab[0] * ar[1]; pm1[5] <= ab[1] * ar[0];
      pm2[0] <= ab[1] * ap[2]; pm2[1] <= ab[2] * ap[1];
      pm2[2] <= ab[2] * ap[0]; pm2[3] <= ab[0] * ap[2];
      pm2[4] <= ab[0] * ap[1]; pm2[5] <= ab[1] * ap[0];
      for (int k = 0; k < 3; k++) begin
        n1[k] <= NW'(pm1[2*k]) - NW'(pm1[2*k+1]);
        n2[k] <= NW'(pm2[2*k]) - NW'(pm2[2*k+1]);
      end
    end
  end

  // stage 4: rescale
  logic [NB-1:0] m1 [3], m2 [3];
  logic [2:0] g1, g2;
  logic z1, z2;
  epdc_normal #(.NW(NW)) u_norm1 (
    .clk(clk), .en(adv), .n0(n1[0]), .n1(n1[1]), .n2(n1[2]),
    .mag0(m1[0]), .mag1(m1[1]), .mag2(m1[2]), .neg(g1), .zero(z1)
  );
  epdc_normal #(.NW(NW)) u_norm2 (
    .clk(clk), .en(adv), .n0(n2[0]), .n1(n2[1]), .n2(n2[2]),
    .mag0(m2[0]), .mag1(m2[1]), .mag2(m2[2]), .neg(g2), .zero(z2)
  );

  // stage 5: products and sums
  logic [SQW-1:0] sq1, sq2;
  logic [DDW-1:0] dmag;
  logic dneg5, deg5;
  logic [2*NB-1:0] pp [3];
  logic [DDW-1:0] ps, ns;
  always_comb begin
    ps = '0;
    ns = '0;
    for (int k = 0; k < 3; k++) begin
      pp[k] = m1[k] * m2[k];
      if (g1[k] != g2[k]) begin
        ns = ns + DDW'(pp[k]);
      end else begin
        ps = ps + DDW'(pp[k]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq1 <= SQW'(m1[0]) * SQW'(m1[0]) + SQW'(m1[1]) * SQW'(m1[1])
           + SQW'(m1[2]) * SQW'(m1[2]);
      sq2 <= SQW'(m2[0]) * SQW'(m2[0]) + SQW'(m2[1]) * SQW'(m2[1])
           + SQW'(m2[2]) * SQW'(m2[2]);
      dneg5 <= ns > ps;
      dmag <= (ns > ps) ? ns - ps : ps - ns;
      deg5 <= z1 | z2;
    end
  end

  // square roots, one result bit per stage, both normals side by side
  logic [SQW-1:0] rv1 [RSTEPS+1], rv2 [RSTEPS+1];
  logic [RW-1:0] rr1 [RSTEPS+1], rr2 [RSTEPS+1];
  logic [DDW-1:0] rd [RSTEPS+1];
  logic rn [RSTEPS+1], rg [RSTEPS+1];
  always_comb begin
    rv1[0] = sq1; rv2[0] = sq2; rr1[0] = '0; rr2[0] = '0;
    rd[0] = dmag; rn[0] = dneg5; rg[0] = deg5;
  end
  for (genvar s = 0; s < RSTEPS; s++) begin : g_sqrt
    localparam int B = RSTEPS - 1 - s;
    logic [SQW+1:0] t1, t2;
    always_comb begin
      t1 = (SQW+2)'(((SQW+2)'({rr1[s]}) << (B+1)) | ((SQW+2)'(1) << (2*B)));
      t2 = (SQW+2)'(((SQW+2)'({rr2[s]}) << (B+1)) | ((SQW+2)'(1) << (2*B)));
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if ((SQW+2)'(rv1[s]) >= t1) begin
          rv1[s+1] <= SQW'((SQW+2)'(rv1[s]) - t1);
          rr1[s+1] <= rr1[s] | (RW'(1) << B);
        end else begin
          rv1[s+1] <= rv1[s];
          rr1[s+1] <= rr1[s];
        end
        if ((SQW+2)'(rv2[s]) >= t2) begin
          rv2[s+1] <= SQW'((SQW+2)'(rv2[s]) - t2);
          rr2[s+1] <= rr2[s] | (RW'(1) << B);
        end else begin
          rv2[s+1] <= rv2[s];
          rr2[s+1] <= rr2[s];
        end
        rd[s+1] <= rd[s];
        rn[s+1] <= rn[s];
        rg[s+1] <= rg[s];
      end
    end
  end

  // denominator product
  logic [SW-1:0] den;
  logic [DDW-1:0] dd;
  logic dn, dg;
  always_ff @(posedge clk) begin
    if (adv) begin
      den <= rr1[RSTEPS] * rr2[RSTEPS];
      dd <= rd[RSTEPS];
      dn <= rn[RSTEPS];
      dg <= rg[RSTEPS];
    end
  end

  // restoring division, one quotient bit per stage; d stays below 2*s so q < 2
  logic [SW:0] qr [QW+1];
  logic [QW-1:0] qq [QW+1];
  logic [SW-1:0] qs [QW+1];
  logic qn [QW+1], qg [QW+1];
  always_comb begin
    qr[0] = (SW+1)'(dd) >> 1;
    qq[0] = '0; qs[0] = den; qn[0] = dn; qg[0] = dg;
  end
  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [SW+1:0] sh;
    always_comb begin
      sh = s == 0 ? (SW+2)'(dd) : (SW+2)'({qr[s], 1'b0});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sh >= (SW+2)'(qs[s])) begin
          qr[s+1] <= (SW+1)'(sh - (SW+2)'(qs[s]));
          qq[s+1] <= {qq[s][QW-2:0], 1'b1};
        end else begin
          qr[s+1] <= (SW+1)'(sh);
          qq[s+1] <= {qq[s][QW-2:0], 1'b0};
        end
        qs[s+1] <= qs[s];
        qn[s+1] <= qn[s];
        qg[s+1] <= qg[s];
      end
    end
  end

  // clamp, snap and sign
  logic [QW-1:0] qf, qc;
  always_comb begin
    qf = qq[QW] >> 1;
    qc = (qf > One) ? One : qf;
    if (!qn[QW] && longint'(qc) > PosLim) begin
      qc = One;
    end
    if (qn[QW] && longint'(qc) > NegLim) begin
      qc = One;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= qg[QW];
      cosine <= qg[QW] ? '0 : (qn[QW] ? QW'(-qc) : qc);
    end
  end
  assign out_valid = vld[ST-1];
endmodule

>>> test/testbench.sv
// self-checking testbench for edge_plane_dihedral_cosine: random and directed query points,
// predicted cosine and degenerate flag checked against each output item in order
// depends on epdc_pkg and the design sources
module testbench;

  localparam int CW = epdc_pkg::CoordWidth;
  localparam int CF = 15;
  localparam int NB = epdc_pkg::NormBits;
  localparam int PW = epdc_pkg::PointWidth;
  localparam int IW = epdc_pkg::RegIdxWidth;
  localparam int LIMIT = 600000;
  localparam logic [IW-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
  } query_t;
  typedef struct {
    logic signed [CF+1:0] cosine;
    logic degenerate;
  } cos_t;
  typedef longint vec3_t [3];
  typedef longint unsigned uvec3_t [3];

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [PW-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready, degenerate;
  logic signed [CW-1:0] query_x, query_y, query_z;
  logic signed [CF+1:0] cosine;

  query_t pending_queries[$];
  cos_t expected_cosines[$];
  logic [PW-1:0] pt_a, pt_b, pt_r;
  int send_idle_pct, recv_stall_pct;
  int errors, cycles;
  logic in_fire;

  edge_plane_dihedral_cosine DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint coord(logic [PW-1:0] w, int k);
    logic signed [CW-1:0] t;
    t = w[k*CW +: CW];
    return t;
  endfunction

  function automatic bit rescale(vec3_t n, output uvec3_t m, output bit ng[3]);
    longint unsigned mx;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      ng[k] = n[k] < 0;
      m[k] = ng[k] ? -n[k] : n[k];
      if (m[k] > mx) mx = m[k];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << NB)) begin
      for (int k = 0; k < 3; k++) m[k] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << (NB - 1))) begin
      for (int k = 0; k < 3; k++) m[k] <<= 1;
      mx <<= 1;
    end
    return 1;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cos_t dihedral_cosine(query_t p);
    vec3_t ab, ar, ap, n1, n2;
    uvec3_t m1, m2;
    bit g1[3], g2[3];
    bit ok1, ok2, dneg;
    longint unsigned sq1, sq2, pos, negs, d, s, q, rem, one;
    longint pc[3];
    cos_t res;
    pc[0] = p.x;
    pc[1] = p.y;
    pc[2] = p.z;
    for (int k = 0; k < 3; k++) begin
      ab[k] = coord(pt_b, k) - coord(pt_a, k);
      ar[k] = coord(pt_r, k) - coord(pt_a, k);
      ap[k] = pc[k] - coord(pt_a, k);
    end
    n1[0] = ab[1] * ar[2] - ab[2] * ar[1];
    n1[1] = ab[2] * ar[0] - ab[0] * ar[2];
    n1[2] = ab[0] * ar[1] - ab[1] * ar[0];
    n2[0] = ab[1] * ap[2] - ab[2] * ap[1];
    n2[1] = ab[2] * ap[0] - ab[0] * ap[2];
    n2[2] = ab[0] * ap[1] - ab[1] * ap[0];
    ok1 = rescale(n1, m1, g1);
    ok2 = rescale(n2, m2, g2);
    if (!ok1 || !ok2) begin
      res.cosine = '0;
      res.degenerate = 1'b1;
      return res;
    end
    sq1 = 0; sq2 = 0; pos = 0; negs = 0;
    for (int k = 0; k < 3; k++) begin
      sq1 += m1[k] * m1[k];
      sq2 += m2[k] * m2[k];
      if (g1[k] != g2[k]) negs += m1[k] * m2[k];
      else pos += m1[k] * m2[k];
    end
    dneg = negs > pos;
    d = dneg ? negs - pos : pos - negs;
    s = floor_sqrt(sq1) * floor_sqrt(sq2);
    q = d / s;
    rem = d % s;
    for (int k = 0; k < CF; k++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= s) begin
        rem -= s;
        q |= 1;
      end
    end
    one = 64'd1 << CF;
    if (q > one) q = one;
    if (!dneg && q * 64'd1000000000 > (64'd999999999 << CF)) q = one;
    if (dneg && q * 64'd100000000 > (64'd99999999 << CF)) q = one;
    res.cosine = (CF+2)'(dneg ? -q : q);
    res.degenerate = 1'b0;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    logic nv;
    query_t it;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      nv = in_valid && !in_fire;
      if (!nv && pending_queries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_queries.pop_front();
        query_x <= it.x;
        query_y <= it.y;
        query_z <= it.z;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    cos_t e;
    query_t p;
    in_fire <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      p.x = query_x;
      p.y = query_y;
      p.z = query_z;
      expected_cosines.push_back(dihedral_cosine(p));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_cosines.size() == 0) begin
        $error("unexpected output item cosine=%0d degenerate=%0d", cosine, degenerate);
        errors++;
      end else begin
        e = expected_cosines.pop_front();
        if (cosine !== e.cosine) begin
          $error("cosine expected %0d actual %0d", e.cosine, cosine);
          errors++;
        end
        if (degenerate !== e.degenerate) begin
          $error("degenerate expected %0d actual %0d", e.degenerate, degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_queries.size() > 0 || expected_cosines.size() > 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [PW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      epdc_pkg::REG_EDGE_START: pt_a = val;
      epdc_pkg::REG_EDGE_END:   pt_b = val;
      epdc_pkg::REG_REFERENCE:  pt_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CW-1:0] rand_coord(int kind);
    case (kind)
      0: return CW'($urandom_range(0, (1 << CW) - 1));
      1: return CW'($urandom_range(0, 64) - 32);
      default: begin
        case ($urandom_range(3))
          0: return {1'b1, {(CW-1){1'b0}}};
          1: return {1'b0, {(CW-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [PW-1:0] rand_point(int kind);
    return {rand_coord(kind), rand_coord(kind), rand_coord(kind)};
  endfunction

  function automatic query_t mk(longint x, longint y, longint z);
    query_t q;
    q.x = CW'(x);
    q.y = CW'(y);
    q.z = CW'(z);
    return q;
  endfunction

  // query point drawn around the configured geometry or at random
  function automatic query_t rand_query();
    longint c[3];
    longint t;
    int kind;
    kind = $urandom_range(9);
    t = longint'($urandom_range(4)) - 1;
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0, 1: c[k] = longint'(rand_coord(0));
        2: c[k] = longint'(rand_coord(2));
        3: c[k] = coord(pt_a, k) + t * (coord(pt_b, k) - coord(pt_a, k));
        4, 5: c[k] = coord(pt_r, k) + longint'($urandom_range(6)) - 3;
        6, 7: c[k] = 2 * coord(pt_a, k) - coord(pt_r, k) + longint'($urandom_range(6)) - 3;
        default: c[k] = coord(pt_a, k) + longint'($urandom_range(2000)) - 1000;
      endcase
    end
    return mk(c[0], c[1], c[2]);
  endfunction

  initial begin
    int per_phase;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = epdc_pkg::REG_EDGE_START;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_fire = 1'b0;
    query_x = '0;
    query_y = '0;
    query_z = '0;
    pt_a = '0;
    pt_b = '0;
    pt_r = '0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero-length edge after reset
    pending_queries.push_back(mk(5, 7, -3));
    wait_idle();
    write_reg(epdc_pkg::REG_EDGE_START, {20'sd0, 20'sd0, 20'sd0});
    write_reg(epdc_pkg::REG_EDGE_END, {20'sd0, 20'sd0, 20'sd2560});
    write_reg(epdc_pkg::REG_REFERENCE, {20'sd0, 20'sd2560, 20'sd0});
    write_reg(REG_UNUSED, '1);
    pending_queries.push_back(mk(0, 2560, 0));
    pending_queries.push_back(mk(0, -2560, 0));
    pending_queries.push_back(mk(0, 0, 0));
    pending_queries.push_back(mk(1280, 0, 0));
    pending_queries.push_back(mk(0, 0, 9999));
    pending_queries.push_back(mk(2560, 2560, 7));
    pending_queries.push_back(mk(-1, 2560, 3));
    pending_queries.push_back(mk(1, 100000, 0));
    pending_queries.push_back(mk(1, -100000, 0));
    pending_queries.push_back(mk(-524288, -524288, -524288));
    pending_queries.push_back(mk(524287, 524287, 524287));
    pending_queries.push_back(mk(-524288, 524287, 0));
    pending_queries.push_back(mk(524287, -524288, -1));
    pending_queries.push_back(mk(-1, -1, -1));
    wait_idle();
    // reference on the edge line
    write_reg(epdc_pkg::REG_REFERENCE, {20'sd0, 20'sd0, 20'sd77});
    pending_queries.push_back(mk(3, 4, 5));
    wait_idle();
    // extreme corners
    write_reg(epdc_pkg::REG_EDGE_START, {1'b1, 19'd0, 1'b1, 19'd0, 1'b1, 19'd0});
    write_reg(epdc_pkg::REG_EDGE_END,
              {1'b0, {19{1'b1}}, 1'b0, {19{1'b1}}, 1'b0, {19{1'b1}}});
    write_reg(epdc_pkg::REG_REFERENCE, {1'b1, 19'd0, 1'b0, {19{1'b1}}, 1'b1, 19'd0});
    pending_queries.push_back(mk(524287, -524288, 524287));
    pending_queries.push_back(mk(-524288, 524287, -524288));
    pending_queries.push_back(mk(0, 0, 0));
    pending_queries.push_back(mk(-524288, -524288, 524287));

    per_phase = 103;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_reg(epdc_pkg::REG_EDGE_START, rand_point(ph % 3));
      write_reg(epdc_pkg::REG_EDGE_END, rand_point((ph + 1) % 3));
      write_reg(epdc_pkg::REG_REFERENCE, rand_point((ph + 2) % 3));
      if (ph == 5) write_reg(REG_UNUSED, rand_point(0));
      for (int i = 0; i < per_phase; i++) begin
        pending_queries.push_back(rand_query());
        if (ph == 3 && i == 50) begin
          while (pending_queries.size() > 0 || expected_cosines.size() > 0 || in_valid)
            @(posedge clk);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
